### rtl/rpip_pkg.sv
// Package for the radix prefix integer parser: shared types and constants.
// Used by every module under rtl/ but rpip_fifo. Depends on nothing.
package rpip_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int MID_DEPTH      = 4;
	localparam int OUT_DEPTH      = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_UP_B  = 8'h42;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2,
		RADIX_BIN = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		POS_FIRST      = 2'd0,
		POS_AFTER_ZERO = 2'd1,
		POS_DIGITS     = 2'd2
	} pos_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         radix_code;
		logic               overflow;
		logic               bad_digit;
	} out_t;

	// classified character handed from front to back
	typedef struct packed {
		logic       clear;
		logic       take_valid;
		logic       bad;
		logic [3:0] digit;
		radix_t     radix;
		logic       last;
	} op_t;

endpackage

### rtl/rpip_fifo.sv
// Small register queue with first-word fall-through, generic word type.
// Depends on nothing.
module rpip_fifo #(
	parameter int  DEPTH = 4,
	parameter type T     = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/rpip_front.sv
// Front end: tracks prefix position and radix, decodes each character into
// a digit op for the back end. Depends on rpip_pkg.
module rpip_front
	import rpip_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  in_t  item,
	output op_t  op
);
	pos_t       pos_q, pos_d;
	radix_t     radix_q, radix_d, radix_n;
	logic       take;
	logic       is_digit;
	logic [3:0] dig;
	logic [4:0] rval;

	function automatic logic [4:0] radix_value(radix_t r);
		logic [4:0] v;
		case (r)
			RADIX_OCT: v = 5'd8;
			RADIX_HEX: v = 5'd16;
			RADIX_BIN: v = 5'd2;
			default:   v = 5'd10;
		endcase
		return v;
	endfunction

	// next state
	always_comb begin
		pos_d   = pos_q;
		radix_n = radix_q;
		take    = 1'b1;
		case (pos_q)
			POS_FIRST: begin
				if (item.ch == CH_ZERO) begin
					radix_n = RADIX_OCT;
					pos_d   = POS_AFTER_ZERO;
					take    = 1'b0;
				end else begin
					radix_n = RADIX_DEC;
					pos_d   = POS_DIGITS;
				end
			end
			POS_AFTER_ZERO: begin
				pos_d = POS_DIGITS;
				if (item.ch inside {CH_LO_X, CH_UP_X}) begin
					radix_n = RADIX_HEX;
					take    = 1'b0;
				end else if (item.ch inside {CH_LO_B, CH_UP_B}) begin
					radix_n = RADIX_BIN;
					take    = 1'b0;
				end else begin
					radix_n = RADIX_OCT;
				end
			end
			default: begin
				pos_d = POS_DIGITS;
			end
		endcase
		radix_d = radix_n;
		if (item.is_last) begin
			pos_d   = POS_FIRST;
			radix_d = RADIX_DEC;
		end
	end

	// outputs
	always_comb begin
		is_digit = 1'b1;
		dig      = '0;
		if (item.ch inside {[CH_ZERO:CH_NINE]}) begin
			dig = 4'(item.ch - CH_ZERO);
		end else if (item.ch inside {[CH_LO_A:CH_LO_F]}) begin
			dig = 4'(item.ch - CH_LO_A + 8'd10);
		end else if (item.ch inside {[CH_UP_A:CH_UP_F]}) begin
			dig = 4'(item.ch - CH_UP_A + 8'd10);
		end else begin
			is_digit = 1'b0;
		end
		rval          = radix_value(radix_n);
		op.clear      = (pos_q == POS_FIRST);
		op.take_valid = take && is_digit && ({1'b0, dig} < rval);
		op.bad        = take && !(is_digit && ({1'b0, dig} < rval));
		op.digit      = dig;
		op.radix      = radix_n;
		op.last       = item.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_FIRST;
			radix_q <= RADIX_DEC;
		end else if (accept) begin
			pos_q   <= pos_d;
			radix_q <= radix_d;
		end
	end

endmodule

### rtl/rpip_back.sv
// Back end: accumulates digits with saturation and forms the result word.
// Depends on rpip_pkg.
module rpip_back
	import rpip_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	input  op_t  op,
	output logic op_pop,
	input  logic res_full,
	output logic res_push,
	output out_t res
);
	localparam int PW = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] VMAX = '1;

	logic [VALUE_BITS-1:0] accum_q, accum_d, base;
	logic                  ovf_q, ovf_d, bad_q, bad_d;
	logic [PW-1:0]         wide, prod, sum;

	assign op_pop   = op_valid && (!op.last || !res_full);
	assign res_push = op_pop && op.last;

	always_comb begin
		base  = op.clear ? '0 : accum_q;
		ovf_d = op.clear ? 1'b0 : ovf_q;
		bad_d = (op.clear ? 1'b0 : bad_q) | op.bad;
		wide  = PW'(base);
		case (op.radix)
			RADIX_BIN: prod = wide << 1;
			RADIX_OCT: prod = wide << 3;
			RADIX_HEX: prod = wide << 4;
			default:   prod = (wide << 3) + (wide << 1);
		endcase
		sum     = prod + PW'(op.digit);
		accum_d = base;
		if (op.take_valid) begin
			if (|sum[PW-1:VALUE_BITS]) begin
				accum_d = VMAX;
				ovf_d   = 1'b1;
			end else begin
				accum_d = sum[VALUE_BITS-1:0];
			end
		end
		res.value      = VALUE_W'(accum_d);
		res.radix_code = op.radix;
		res.overflow   = ovf_d;
		res.bad_digit  = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else if (op_pop) begin
			accum_q <= accum_d;
			ovf_q   <= ovf_d;
			bad_q   <= bad_d;
		end
	end

endmodule

### rtl/radix_prefix_integer_parser.sv
// Radix prefix integer parser, top level: front, op queue, back, result queue.
// Throughput: one character per cycle, sustained, with pop held high.
// A final character is queued as an op, then its result in the result queue.
// The op queue (4 words) and result queue (2 words) decouple the two sides.
// Reset (arst_n low) empties both queues and returns the parser to first char.
// Depends on rpip_pkg, rpip_front, rpip_fifo, rpip_back.
module radix_prefix_integer_parser
	import rpip_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  in_t  item,
	output logic full,
	input  logic pop,
	output out_t result,
	output logic empty
);
	op_t  front_op, mid_op;
	logic accept;
	logic mid_full, mid_empty, mid_pop;
	logic out_full, out_push;
	out_t back_res;

	assign accept = push && !mid_full;
	assign full   = mid_full;

	rpip_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.op     (front_op)
	);

	rpip_fifo #(.DEPTH(MID_DEPTH), .T(op_t)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (front_op),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_op),
		.empty  (mid_empty)
	);

	rpip_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!mid_empty),
		.op       (mid_op),
		.op_pop   (mid_pop),
		.res_full (out_full),
		.res_push (out_push),
		.res      (back_res)
	);

	rpip_fifo #(.DEPTH(OUT_DEPTH), .T(out_t)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

`ifndef SYNTHESIS
	localparam logic [VALUE_BITS-1:0] VMAX_CHK = '1;

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.overflow |-> result.value == VALUE_W'(VMAX_CHK))
		else $error("overflowed result not saturated");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result written into full queue");

	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("op consumed from empty queue");
`endif

endmodule
